// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define HSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define HSH_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/hsh_pkg.sv =====
// ----------------------------------------------------------------------------
// hsh_pkg
// Types and constants shared by the hyperplane sign hash modules.
// ----------------------------------------------------------------------------
package hsh_pkg;

    localparam int VECTOR_LENGTH_DEF    = 128;
    localparam int PLANES_DEF           = 8;
    localparam int POINT_COUNT_BITS_DEF = 20;

    localparam int PLANE_IDX_W = 3;
    localparam int ELEM_IDX_W  = 7;
    localparam int VALUE_W     = 16;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int ACC_W       = 48;
    localparam int HASH_W      = 8;
    localparam int PNUM_W      = 20;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] PLANES_USED_RESET = CFG_W'(8);

    // Result queue depth; a power of two so the pointers wrap naturally.
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_POINT = 1'b1
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [PLANE_IDX_W-1:0]    plane_index;
        logic [ELEM_IDX_W-1:0]     element_index;
        logic signed [VALUE_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [HASH_W-1:0] hash_code;
        logic [PNUM_W-1:0] point_number;
    } t_out_item;

    // Pipeline control handed from the top level to every plane lane.
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
        logic s2_last;
    } t_lane_ctl;

endpackage

// ===== rtl/hsh_ram.sv =====
// ----------------------------------------------------------------------------
// hsh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsh_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/hsh_lane.sv =====
// ----------------------------------------------------------------------------
// hsh_lane
// One hyperplane: weight store, product register and 48-bit accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsh_lane #(
    parameter  int VECTOR_LENGTH = hsh_pkg::VECTOR_LENGTH_DEF,
    localparam int AW            = $clog2(VECTOR_LENGTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_addr,
    input  logic signed [hsh_pkg::VALUE_W-1:0] i_wr_data,
    input  logic signed [hsh_pkg::VALUE_W-1:0] i_s1_value,
    input  hsh_pkg::t_lane_ctl                i_ctl,
    output logic                              o_positive
);

    logic signed [hsh_pkg::VALUE_W-1:0] weight;
    logic signed [hsh_pkg::PROD_W-1:0]  r_prod;
    logic signed [hsh_pkg::ACC_W-1:0]   r_acc;
    logic signed [hsh_pkg::ACC_W-1:0]   n_sum;
    logic signed [hsh_pkg::ACC_W-1:0]   n_acc;

    hsh_ram #(
        .WIDTH (hsh_pkg::VALUE_W),
        .DEPTH (VECTOR_LENGTH)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_addr),
        .o_rd_data (weight)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_valid) begin
            r_prod <= weight * i_s1_value;
        end
    end

    always_comb begin
        n_sum = r_acc + hsh_pkg::ACC_W'(r_prod);
        n_acc = r_acc;
        if (i_ctl.s2_valid) begin
            n_acc = i_ctl.s2_last ? '0 : n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Strictly positive dot product including the element now being added.
    assign o_positive = (n_sum != '0) && !n_sum[hsh_pkg::ACC_W-1];

    `HSH_ASSERT(a_acc_cleared, i_ctl.s2_valid && i_ctl.s2_last |=> r_acc == '0,
                "accumulator not cleared after the end of a point")

endmodule

// ===== rtl/hsh_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hsh_out_fifo
// Small result queue that decouples the pipeline from the output side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsh_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  hsh_pkg::t_out_item                 i_push_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output hsh_pkg::t_out_item                 o_data,
    output logic [hsh_pkg::OUT_CNT_W-1:0]      o_count
);

    hsh_pkg::t_out_item                 r_mem [hsh_pkg::OUT_FIFO_DEPTH];
    logic [hsh_pkg::OUT_PTR_W-1:0]      r_wr_ptr;
    logic [hsh_pkg::OUT_PTR_W-1:0]      r_rd_ptr;
    logic [hsh_pkg::OUT_CNT_W-1:0]      r_count;
    logic                               pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + hsh_pkg::OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + hsh_pkg::OUT_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + hsh_pkg::OUT_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - hsh_pkg::OUT_CNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `HSH_NEVER(a_no_overflow,
               i_push && (r_count == hsh_pkg::OUT_CNT_W'(hsh_pkg::OUT_FIFO_DEPTH)),
               "result pushed into a full queue")

endmodule

// ===== rtl/hyperplane_sign_hash_top.sv =====
// ----------------------------------------------------------------------------
// hyperplane_sign_hash_top
// Random-hyperplane sign hash: per-plane weight stores and dot products.
// ----------------------------------------------------------------------------
//   Channel  | Handshake                      | Payload
//   ---------+--------------------------------+--------------------------
//   input    | i_in_valid / o_in_ready        | i_in_data  (t_in_item)
//   result   | o_out_valid / i_out_ready      | o_out_data (t_out_item)
//   config   | i_cfg_valid / o_cfg_ready      | i_cfg_data (planes_used)
//
// One request is taken per cycle while o_in_ready is high. The weight read,
// the product register and the accumulator form three stages; a hash is
// queued as a point's final element leaves the product register.
// Reset clears the accumulators, the point counter and the queue; weights are
// not cleared. Input ready drops only when the four-entry result queue could
// fill with the results already in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hyperplane_sign_hash_top #(
    parameter int VECTOR_LENGTH    = hsh_pkg::VECTOR_LENGTH_DEF,
    parameter int PLANES           = hsh_pkg::PLANES_DEF,
    parameter int POINT_COUNT_BITS = hsh_pkg::POINT_COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  hsh_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output hsh_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hsh_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(VECTOR_LENGTH);
    localparam int CW = hsh_pkg::OUT_CNT_W;

    logic                                accept;
    logic                                elem_ok;
    logic                                elem_last;
    logic                                point_go;
    logic [AW-1:0]                       addr;
    logic [PLANES-1:0]                   wr_en;
    logic [PLANES-1:0]                   positive;
    logic [hsh_pkg::HASH_W-1:0]          hash;
    hsh_pkg::t_lane_ctl                  lane_ctl;
    hsh_pkg::t_out_item                  push_data;
    logic                                push;
    logic [CW-1:0]                       fifo_count;
    logic [1:0]                          pending;

    logic                                r_s1_valid;
    logic                                r_s1_last;
    logic signed [hsh_pkg::VALUE_W-1:0]  r_s1_value;
    logic                                r_s2_valid;
    logic                                r_s2_last;
    logic [POINT_COUNT_BITS-1:0]         r_point_cnt;
    logic [hsh_pkg::CFG_W-1:0]           r_planes_used;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes_used <= hsh_pkg::PLANES_USED_RESET;
        end else if (i_cfg_valid) begin
            r_planes_used <= i_cfg_data;
        end
    end

    // Results already committed to the pipeline count against queue space.
    assign pending = {1'b0, r_s1_valid && r_s1_last} + {1'b0, r_s2_valid && r_s2_last};
    assign o_in_ready = ({1'b0, fifo_count} + (CW + 1)'(pending))
                        < (CW + 1)'(hsh_pkg::OUT_FIFO_DEPTH);

    assign accept    = i_in_valid && o_in_ready;
    assign elem_ok   = 32'(i_in_data.element_index) < 32'(VECTOR_LENGTH);
    assign elem_last = 32'(i_in_data.element_index) == (32'(VECTOR_LENGTH) - 32'd1);
    assign point_go  = accept && (i_in_data.action == hsh_pkg::ACT_POINT) && elem_ok;
    assign addr      = AW'(i_in_data.element_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= point_go;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last  <= elem_last;
        r_s1_value <= i_in_data.element_value;
        r_s2_last  <= r_s1_last;
    end

    assign lane_ctl.s1_valid = r_s1_valid;
    assign lane_ctl.s2_valid = r_s2_valid;
    assign lane_ctl.s2_last  = r_s2_last;

    for (genvar g = 0; g < PLANES; g++) begin : g_lane
        assign wr_en[g] = accept && (i_in_data.action == hsh_pkg::ACT_LOAD) && elem_ok
                          && (32'(i_in_data.plane_index) == g);

        hsh_lane #(
            .VECTOR_LENGTH (VECTOR_LENGTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (wr_en[g]),
            .i_rd_en    (point_go),
            .i_addr     (addr),
            .i_wr_data  (i_in_data.element_value),
            .i_s1_value (r_s1_value),
            .i_ctl      (lane_ctl),
            .o_positive (positive[g])
        );
    end

    for (genvar j = 0; j < hsh_pkg::HASH_W; j++) begin : g_hash
        if (j < PLANES) begin : g_used
            assign hash[j] = positive[j] && (hsh_pkg::CFG_W'(j) < r_planes_used);
        end else begin : g_zero
            assign hash[j] = 1'b0;
        end
    end

    assign push                   = r_s2_valid && r_s2_last;
    assign push_data.hash_code    = hash;
    assign push_data.point_number = hsh_pkg::PNUM_W'(r_point_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_cnt <= '0;
        end else if (push) begin
            r_point_cnt <= r_point_cnt + POINT_COUNT_BITS'(1);
        end
    end

    hsh_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data),
        .o_count     (fifo_count)
    );

    `HSH_ASSERT(a_cnt_step, push |=> r_point_cnt == $past(r_point_cnt) + POINT_COUNT_BITS'(1),
                "point counter did not advance after a result")
    `HSH_ASSERT(a_s1_from_accept, r_s1_valid |-> $past(i_in_valid && o_in_ready),
                "first stage holds a request that was never accepted")

endmodule

// ===== tb/sv/tb_hyperplane_sign_hash_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hyperplane_sign_hash_top
// The testbench loads hyperplane weights and streams point elements through
// the sign hash block. An in-order model keeps its own weights, 48-bit dot
// products and point counter, and every hash result is compared against it.
// Each phase uses its own plane count; phases share valid/ready gap patterns in pairs.
// ----------------------------------------------------------------------------
module tb_hyperplane_sign_hash_top;

    localparam int VLEN             = hsh_pkg::VECTOR_LENGTH_DEF;
    localparam int NPLANES          = hsh_pkg::PLANES_DEF;
    localparam int ELEM_LAST        = VLEN - 1;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 222;
    localparam int SETTLE_CYCLES    = 12;

    localparam logic [hsh_pkg::CFG_W-1:0] PLANE_SETTINGS [PHASES] =
        '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd3};
    localparam logic signed [hsh_pkg::VALUE_W-1:0] END_WEIGHTS [NPLANES] =
        '{16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
          16'sh0000, 16'sh4000, 16'shFFFE, 16'sh3039};
    localparam logic signed [hsh_pkg::VALUE_W-1:0] FIRST_WEIGHTS [NPLANES] =
        '{16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0001,
          16'sh0000, 16'sh0005, 16'shFFFB, 16'sh0064};

    class sign_hash_checker;
        logic signed [hsh_pkg::VALUE_W-1:0] weights [NPLANES * VLEN];
        logic signed [hsh_pkg::ACC_W-1:0]   dot_sums [NPLANES];
        logic [hsh_pkg::PNUM_W-1:0]         point_seq;
        logic [hsh_pkg::CFG_W-1:0]          planes_used;
        hsh_pkg::t_out_item                 hashes_due [$];
        int unsigned                        errors;
        int unsigned                        hashes_checked;

        function new();
            foreach (weights[i]) weights[i] = '0;
            foreach (dot_sums[j]) dot_sums[j] = '0;
            point_seq      = '0;
            planes_used    = hsh_pkg::PLANES_USED_RESET;
            errors         = 0;
            hashes_checked = 0;
        endfunction

        function void take_request(hsh_pkg::t_in_item req);
            logic signed [hsh_pkg::VALUE_W-1:0] pval;
            int unsigned                        active;
            hsh_pkg::t_out_item                 res;
            pval = req.element_value;
            if (req.action == hsh_pkg::ACT_LOAD) begin
                weights[req.plane_index * VLEN + req.element_index] = pval;
                return;
            end
            // Operands widen to 48 bits before the multiply, so sums are exact.
            for (int j = 0; j < NPLANES; j++) begin
                dot_sums[j] = dot_sums[j]
                    + weights[j * VLEN + req.element_index] * pval;
            end
            if (req.element_index != ELEM_LAST) return;
            active = (planes_used > NPLANES) ? NPLANES : planes_used;
            res.hash_code = '0;
            for (int j = 0; j < active; j++) begin
                if (dot_sums[j] > 48'sd0) res.hash_code[j] = 1'b1;
            end
            res.point_number = point_seq;
            point_seq++;
            foreach (dot_sums[j]) dot_sums[j] = '0;
            hashes_due.push_back(res);
        endfunction

        function void compare_hash(hsh_pkg::t_out_item got);
            hsh_pkg::t_out_item want;
            if (hashes_due.size() == 0) begin
                $error("unexpected hash result: hash_code %02h point_number %0d",
                       got.hash_code, got.point_number);
                errors++;
                return;
            end
            want = hashes_due.pop_front();
            hashes_checked++;
            if (got.hash_code !== want.hash_code) begin
                $error("hash_code: expected %02h, actual %02h",
                       want.hash_code, got.hash_code);
                errors++;
            end
            if (got.point_number !== want.point_number) begin
                $error("point_number: expected %0d, actual %0d",
                       want.point_number, got.point_number);
                errors++;
            end
        endfunction

        function int unsigned due_count();
            return hashes_due.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    hsh_pkg::t_in_item             i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    hsh_pkg::t_out_item            o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [hsh_pkg::CFG_W-1:0]     i_cfg_data;

    sign_hash_checker    hash_chk;
    int unsigned         send_gap_pct;
    int unsigned         recv_stall_pct;
    int unsigned         items_sent;
    bit                  weight_set [NPLANES][VLEN];
    bit                  elem_ready [VLEN];
    int unsigned         ready_elems [$];

    hyperplane_sign_hash_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: the ready pattern is redrawn every cycle.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) hash_chk.compare_hash(o_out_data);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [hsh_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return $urandom_range(1) ? 16'sh0001 : 16'shFFFF;
            default: return hsh_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Point elements may only use positions whose weights exist on every plane.
    function automatic int unsigned pick_body_elem();
        int unsigned e;
        do e = ready_elems[$urandom_range(ready_elems.size() - 1)];
        while (e == ELEM_LAST);
        return e;
    endfunction

    task automatic send_request(input hsh_pkg::t_in_item req);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        hash_chk.take_request(req);
        items_sent++;
    endtask

    task automatic load_weight(input int unsigned plane, input int unsigned elem,
                               input logic signed [hsh_pkg::VALUE_W-1:0] w);
        hsh_pkg::t_in_item req;
        bit                full;
        req.action        = hsh_pkg::ACT_LOAD;
        req.plane_index   = hsh_pkg::PLANE_IDX_W'(plane);
        req.element_index = hsh_pkg::ELEM_IDX_W'(elem);
        req.element_value = w;
        send_request(req);
        weight_set[plane][elem] = 1'b1;
        full = 1'b1;
        for (int p = 0; p < NPLANES; p++) full &= weight_set[p][elem];
        if (full && !elem_ready[elem]) begin
            elem_ready[elem] = 1'b1;
            ready_elems.push_back(elem);
        end
    endtask

    task automatic send_element(input int unsigned elem,
                                input logic signed [hsh_pkg::VALUE_W-1:0] v);
        hsh_pkg::t_in_item req;
        req.action        = hsh_pkg::ACT_POINT;
        req.plane_index   = hsh_pkg::PLANE_IDX_W'($urandom);
        req.element_index = hsh_pkg::ELEM_IDX_W'(elem);
        req.element_value = v;
        send_request(req);
    endtask

    task automatic write_planes_used(input logic [hsh_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        hash_chk.planes_used = value;
    endtask

    // Waits for every hash, then lets loads and open elements clear the pipeline.
    task automatic settle();
        while (hash_chk.due_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        for (int p = 0; p < NPLANES; p++) load_weight(p, ELEM_LAST, END_WEIGHTS[p]);
        for (int p = 0; p < NPLANES; p++) load_weight(p, 0, FIRST_WEIGHTS[p]);
        send_element(0, 16'sh8000);
        send_element(ELEM_LAST, 16'sh7FFF);
        // A point whose dot products are all exactly zero must hash to zero.
        send_element(ELEM_LAST, 16'sh0000);
        send_element(ELEM_LAST, 16'sh8000);
        // Repeated elements all accumulate before the end element.
        send_element(0, 16'sh7FFF);
        send_element(0, 16'sh8001);
        send_element(ELEM_LAST, 16'sh0001);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned start;
        int unsigned roll;
        int unsigned body;
        int unsigned elem;
        start = items_sent;
        while (items_sent - start < quota) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                elem = $urandom_range(ELEM_LAST);
                for (int p = 0; p < NPLANES; p++) load_weight(p, elem, pick_value());
            end else if (roll < 16) begin
                load_weight($urandom_range(NPLANES - 1), $urandom_range(ELEM_LAST),
                            pick_value());
            end else if (roll < 20) begin
                send_element(pick_body_elem(), pick_value());
            end else begin
                body = $urandom_range(5);
                repeat (body) send_element(pick_body_elem(), pick_value());
                send_element(ELEM_LAST, pick_value());
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        items_sent  = 0;
        hash_chk    = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 2) begin
                send_gap_pct   = 9;
                recv_stall_pct = 73;
            end else if (ph < 4) begin
                send_gap_pct   = 73;
                recv_stall_pct = 9;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            if (ph != 0) settle();
            write_planes_used(PLANE_SETTINGS[ph]);
            if (ph == 0) run_directed();
            run_random(RANDOM_PER_PHASE);
            i_in_valid <= 1'b0;
        end
        settle();
        $display("Sent %0d requests and checked %0d hashes across %0d plane counts,",
                 items_sent, hash_chk.hashes_checked, PHASES);
        $display("under sender gaps, receiver stalls and full-rate streaming.");
        if (hash_chk.errors == 0 && hash_chk.due_count() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
